[src/hhph_pkg.sv]
// shared constants, request codes and result beat type for the hit-position histogram
package hhph_pkg;

    localparam int FIBERS         = 29;
    localparam int FIBER_W        = 5;
    localparam int VALUE_BITS     = 24;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int COUNT_BITS     = 32;
    localparam int BIN_W          = 32;
    localparam int SCALED_W       = VALUE_BITS + GAIN_BITS;

    // one table memory per metric, entries ordered axis then fiber
    localparam int TAB_DEPTH = 2 * FIBERS;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int TAB_W     = VALUE_BITS + GAIN_BITS;

    // one histogram memory per metric, entries ordered y then x
    localparam int HIST_DEPTH = FIBERS * FIBERS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [GAIN_BITS-1:0]  GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC_BITS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // result queue, depth must be a power of two
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic               int_hit;
        logic [FIBER_W-1:0] int_x;
        logic [FIBER_W-1:0] int_y;
        logic               peak_hit;
        logic [FIBER_W-1:0] peak_x;
        logic [FIBER_W-1:0] peak_y;
        logic [BIN_W-1:0]   bin_count;
    } result_t;

endpackage

[src/hhph_ram.sv]
// generic single-port-write, single-port-read ram with registered read (old data on collision)
module hhph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/hhph_fifo.sv]
// small result queue between the histogram pipeline and the result channel
module hhph_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hhph_pkg::result_t push_data,
    input  logic              pop,
    output logic              out_valid,
    output hhph_pkg::result_t out_data
);

    hhph_pkg::result_t                 mem_reg [hhph_pkg::FIFO_DEPTH];
    logic [hhph_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [hhph_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [hhph_pkg::FIFO_CW-1:0]      level_reg;
    logic [hhph_pkg::FIFO_CW-1:0]      level_next;

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (level_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

endmodule

[src/hodoscope_hit_position_histogram_top.sv]
// top level of the hodoscope hit-position histogram
//
// input channel (s_*): one request beat per cycle while s_ready is high, valid/ready. a fiber sample
// feeds the integral and peak max searches of its plane; last_of_event closes
// the event. loads write a fiber's threshold and reciprocal gain, reads fetch a
// histogram bin, clears zero both histograms.
// result channel (m_*): one beat for each closing sample (event decision) and
// each bin read, in request order. loads and clears give no beat.
// a result passes the table, max-search and histogram stages, then the result queue.
// throughput: one request per cycle while s_ready is high; tables are read once per sample, the
// histograms get one read-modify-write per metric per event, with one-deep
// forwarding so back-to-back events on the same bin count correctly.
// a clear drops s_ready from its acceptance until the pipeline has drained and
// the histogram sweep (one bin of each metric per cycle, over all 841 bins) has run.
// after reset the same sweep runs before the first request is taken;
// the tables come up as zero threshold and unity gain via per-entry valid bits.
// when the receiver stalls, results collect in an 8-deep queue; apart from clears and the sweep,
// s_ready falls only once every queue slot is spoken for by a result queued or in flight.
module hodoscope_hit_position_histogram_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_req_type,
    input  logic                                   s_axis,
    input  logic [hhph_pkg::FIBER_W-1:0]           s_fiber,
    input  logic [hhph_pkg::FIBER_W-1:0]           s_row,
    input  logic                                   s_metric,
    input  logic signed [hhph_pkg::VALUE_BITS-1:0] s_int_value,
    input  logic signed [hhph_pkg::VALUE_BITS-1:0] s_peak_value,
    input  logic signed [hhph_pkg::VALUE_BITS-1:0] s_threshold_word,
    input  logic [hhph_pkg::GAIN_BITS-1:0]         s_gain_word,
    input  logic                                   s_last_of_event,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_kind,
    output logic                                   m_int_hit,
    output logic [hhph_pkg::FIBER_W-1:0]           m_int_x,
    output logic [hhph_pkg::FIBER_W-1:0]           m_int_y,
    output logic                                   m_peak_hit,
    output logic [hhph_pkg::FIBER_W-1:0]           m_peak_x,
    output logic [hhph_pkg::FIBER_W-1:0]           m_peak_y,
    output logic [hhph_pkg::BIN_W-1:0]             m_bin_count
);

    // ------------------------------------------------------------------
    // request decode and credit tracking
    // ------------------------------------------------------------------
    hhph_pkg::req_t                s_req;
    logic                          s_acc;
    logic                          s_fib_ok;
    logic                          s_makes_result;
    logic [hhph_pkg::TAB_AW-1:0]   tab_addr;
    logic                          tab_we [2];

    logic [hhph_pkg::FIFO_CW-1:0]  cnt_reg;
    logic [hhph_pkg::FIFO_CW-1:0]  cnt_next;
    logic                          sweep_reg;
    logic [hhph_pkg::HIST_AW-1:0]  sweep_addr_reg;
    logic                          clear_pend_reg;
    logic [hhph_pkg::TAB_DEPTH-1:0] tab_valid_reg [2];

    logic                          m_pop;
    logic                          res_push;

    assign s_req    = hhph_pkg::req_t'(s_req_type);
    assign s_ready  = !sweep_reg && !clear_pend_reg &&
                      (cnt_reg < hhph_pkg::FIFO_CW'(hhph_pkg::FIFO_DEPTH));
    assign s_acc    = s_valid && s_ready;
    assign s_fib_ok = (s_fiber < hhph_pkg::FIBER_W'(hhph_pkg::FIBERS));

    // table entry of the fiber on its plane; out-of-range fibers park at entry 0
    always_comb begin
        if (!s_fib_ok) begin
            tab_addr = '0;
        end else if (s_axis) begin
            tab_addr = hhph_pkg::TAB_AW'(hhph_pkg::FIBERS) + hhph_pkg::TAB_AW'(s_fiber);
        end else begin
            tab_addr = hhph_pkg::TAB_AW'(s_fiber);
        end
    end

    always_comb begin
        s_makes_result = 1'b0;
        tab_we[0]      = 1'b0;
        tab_we[1]      = 1'b0;
        case (s_req)
            hhph_pkg::REQ_SAMPLE: s_makes_result = s_last_of_event;
            hhph_pkg::REQ_READ:   s_makes_result = 1'b1;
            hhph_pkg::REQ_LOAD: begin
                tab_we[0] = s_acc && s_fib_ok && !s_metric;
                tab_we[1] = s_acc && s_fib_ok && s_metric;
            end
            default: s_makes_result = 1'b0;
        endcase
    end

    // one credit per result queued or still in the pipeline
    always_comb begin
        cnt_next = cnt_reg;
        if ((s_acc && s_makes_result) && !m_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (m_pop && !(s_acc && s_makes_result)) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // threshold / gain tables: one memory per metric, valid bit per entry
    // ------------------------------------------------------------------
    logic [hhph_pkg::TAB_W-1:0] tab_rdata [2];

    for (genvar g = 0; g < 2; g++) begin : g_tab
        hhph_ram #(
            .WIDTH (hhph_pkg::TAB_W),
            .DEPTH (hhph_pkg::TAB_DEPTH)
        ) u_tab_ram (
            .aclk  (aclk),
            .we    (tab_we[g]),
            .waddr (tab_addr),
            .wdata ({s_threshold_word, s_gain_word}),
            .raddr (tab_addr),
            .rdata (tab_rdata[g])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tab_valid_reg[g] <= '0;
            end else if (tab_we[g]) begin
                tab_valid_reg[g][tab_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: table data back, threshold gate and gain multiply
    // ------------------------------------------------------------------
    logic                                   p1_valid_reg;
    hhph_pkg::req_t                         p1_req_reg;
    logic                                   p1_axis_reg;
    logic [hhph_pkg::FIBER_W-1:0]           p1_fiber_reg;
    logic [hhph_pkg::FIBER_W-1:0]           p1_row_reg;
    logic                                   p1_metric_reg;
    logic                                   p1_fib_ok_reg;
    logic                                   p1_last_reg;
    logic signed [hhph_pkg::VALUE_BITS-1:0] p1_raw_reg [2];
    logic                                   p1_tab_ok_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_req_reg       <= s_req;
            p1_axis_reg      <= s_axis;
            p1_fiber_reg     <= s_fiber;
            p1_row_reg       <= s_row;
            p1_metric_reg    <= s_metric;
            p1_fib_ok_reg    <= s_fib_ok;
            p1_last_reg      <= s_last_of_event;
            p1_raw_reg[0]    <= s_int_value;
            p1_raw_reg[1]    <= s_peak_value;
            // valid bits sampled on the same edge as the ram read
            p1_tab_ok_reg[0] <= tab_valid_reg[0][tab_addr];
            p1_tab_ok_reg[1] <= tab_valid_reg[1][tab_addr];
        end
    end

    logic signed [hhph_pkg::VALUE_BITS-1:0] p1_thr [2];
    logic [hhph_pkg::GAIN_BITS-1:0]         p1_gain [2];
    logic                                   p1_surv [2];
    logic signed [hhph_pkg::SCALED_W:0]     p1_prod_full [2];

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            // never-loaded entries read as zero threshold, unity gain
            if (p1_tab_ok_reg[m]) begin
                p1_thr[m]  = $signed(tab_rdata[m][hhph_pkg::TAB_W-1:hhph_pkg::GAIN_BITS]);
                p1_gain[m] = tab_rdata[m][hhph_pkg::GAIN_BITS-1:0];
            end else begin
                p1_thr[m]  = '0;
                p1_gain[m] = hhph_pkg::GAIN_UNITY;
            end
            p1_surv[m]      = p1_fib_ok_reg && (p1_raw_reg[m] > p1_thr[m]);
            p1_prod_full[m] = p1_raw_reg[m] * $signed({1'b0, p1_gain[m]});
        end
    end

    // ------------------------------------------------------------------
    // stage 2: running maximum per metric and plane, event close
    // ------------------------------------------------------------------
    logic                                 p2_valid_reg;
    hhph_pkg::req_t                       p2_req_reg;
    logic                                 p2_axis_reg;
    logic [hhph_pkg::FIBER_W-1:0]         p2_fiber_reg;
    logic [hhph_pkg::FIBER_W-1:0]         p2_row_reg;
    logic                                 p2_metric_reg;
    logic                                 p2_last_reg;
    logic                                 p2_surv_reg [2];
    logic signed [hhph_pkg::SCALED_W-1:0] p2_prod_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p2_req_reg    <= p1_req_reg;
        p2_axis_reg   <= p1_axis_reg;
        p2_fiber_reg  <= p1_fiber_reg;
        p2_row_reg    <= p1_row_reg;
        p2_metric_reg <= p1_metric_reg;
        p2_last_reg   <= p1_last_reg;
        for (int m = 0; m < 2; m++) begin
            p2_surv_reg[m] <= p1_surv[m];
            p2_prod_reg[m] <= $signed(p1_prod_full[m][hhph_pkg::SCALED_W-1:0]);
        end
    end

    // best state indexed [metric][plane]
    logic signed [hhph_pkg::SCALED_W-1:0] best_scaled_reg [2][2];
    logic [hhph_pkg::FIBER_W-1:0]         best_fiber_reg [2][2];
    logic                                 best_found_reg [2][2];

    logic                                 p2_sample;
    logic                                 p2_close;
    logic                                 better [2];
    logic                                 upd [2];
    logic                                 found_after [2][2];
    logic [hhph_pkg::FIBER_W-1:0]         fiber_after [2][2];

    assign p2_sample = p2_valid_reg && (p2_req_reg == hhph_pkg::REQ_SAMPLE);
    assign p2_close  = p2_sample && p2_last_reg;

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            // strict greater wins; on equal products the lower fiber wins
            better[m] = !best_found_reg[m][p2_axis_reg] ||
                        (p2_prod_reg[m] > best_scaled_reg[m][p2_axis_reg]) ||
                        ((p2_prod_reg[m] == best_scaled_reg[m][p2_axis_reg]) &&
                         (p2_fiber_reg < best_fiber_reg[m][p2_axis_reg]));
            upd[m] = p2_sample && p2_surv_reg[m] && better[m];
            for (int a = 0; a < 2; a++) begin
                if (upd[m] && (p2_axis_reg == 1'(a))) begin
                    found_after[m][a] = 1'b1;
                    fiber_after[m][a] = p2_fiber_reg;
                end else begin
                    found_after[m][a] = best_found_reg[m][a];
                    fiber_after[m][a] = best_found_reg[m][a] ? best_fiber_reg[m][a] : '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < 2; m++) begin
                best_found_reg[m][0] <= 1'b0;
                best_found_reg[m][1] <= 1'b0;
            end
        end else if (p2_close) begin
            for (int m = 0; m < 2; m++) begin
                best_found_reg[m][0] <= 1'b0;
                best_found_reg[m][1] <= 1'b0;
            end
        end else begin
            for (int m = 0; m < 2; m++) begin
                if (upd[m]) begin
                    best_found_reg[m][p2_axis_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int m = 0; m < 2; m++) begin
            if (upd[m]) begin
                best_scaled_reg[m][p2_axis_reg] <= p2_prod_reg[m];
                best_fiber_reg[m][p2_axis_reg]  <= p2_fiber_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: bin address and histogram read
    // ------------------------------------------------------------------
    logic                           p3_valid_reg;
    logic                           p3_event_reg;
    logic                           p3_read_reg;
    logic                           p3_clear_reg;
    logic                           p3_hit_reg [2];
    logic [hhph_pkg::FIBER_W-1:0]   p3_x_reg [2];
    logic [hhph_pkg::FIBER_W-1:0]   p3_y_reg [2];
    logic                           p3_metric_reg;
    logic                           p3_rb_ok_reg;
    logic                           p2_rb_ok;

    assign p2_rb_ok = (p2_fiber_reg < hhph_pkg::FIBER_W'(hhph_pkg::FIBERS)) &&
                      (p2_row_reg < hhph_pkg::FIBER_W'(hhph_pkg::FIBERS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p3_event_reg  <= p2_close;
        p3_read_reg   <= p2_req_reg == hhph_pkg::REQ_READ;
        p3_clear_reg  <= p2_req_reg == hhph_pkg::REQ_CLEAR;
        p3_metric_reg <= p2_metric_reg;
        p3_rb_ok_reg  <= p2_rb_ok;
        for (int m = 0; m < 2; m++) begin
            p3_hit_reg[m] <= found_after[m][0] && found_after[m][1];
            if (p2_req_reg == hhph_pkg::REQ_READ) begin
                // readback shares the address path, parked at bin 0 when out of range
                p3_x_reg[m] <= p2_rb_ok ? p2_fiber_reg : '0;
                p3_y_reg[m] <= p2_rb_ok ? p2_row_reg : '0;
            end else begin
                p3_x_reg[m] <= fiber_after[m][0];
                p3_y_reg[m] <= fiber_after[m][1];
            end
        end
    end

    logic [hhph_pkg::HIST_AW-1:0] p3_addr [2];

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            p3_addr[m] = hhph_pkg::HIST_AW'(p3_y_reg[m]) * hhph_pkg::HIST_AW'(hhph_pkg::FIBERS) +
                         hhph_pkg::HIST_AW'(p3_x_reg[m]);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: histogram data back, saturating increment and write back
    // ------------------------------------------------------------------
    logic                              p4_valid_reg;
    logic                              p4_event_reg;
    logic                              p4_read_reg;
    logic                              p4_clear_reg;
    logic                              p4_hit_reg [2];
    logic [hhph_pkg::FIBER_W-1:0]      p4_x_reg [2];
    logic [hhph_pkg::FIBER_W-1:0]      p4_y_reg [2];
    logic                              p4_metric_reg;
    logic                              p4_rb_ok_reg;
    logic [hhph_pkg::HIST_AW-1:0]      p4_addr_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p4_event_reg  <= p3_event_reg;
        p4_read_reg   <= p3_read_reg;
        p4_clear_reg  <= p3_clear_reg;
        p4_metric_reg <= p3_metric_reg;
        p4_rb_ok_reg  <= p3_rb_ok_reg;
        for (int m = 0; m < 2; m++) begin
            p4_hit_reg[m]  <= p3_hit_reg[m];
            p4_x_reg[m]    <= p3_x_reg[m];
            p4_y_reg[m]    <= p3_y_reg[m];
            p4_addr_reg[m] <= p3_addr[m];
        end
    end

    logic [hhph_pkg::COUNT_BITS-1:0] hist_rdata [2];
    logic [hhph_pkg::COUNT_BITS-1:0] hist_cur [2];
    logic [hhph_pkg::COUNT_BITS-1:0] hist_inc [2];
    logic                            inc_we [2];
    logic                            hist_we [2];
    logic [hhph_pkg::HIST_AW-1:0]    hist_waddr [2];
    logic [hhph_pkg::COUNT_BITS-1:0] hist_wdata [2];

    // last write of each histogram, covers the read that shared its edge
    logic                            fwd_valid_reg [2];
    logic [hhph_pkg::HIST_AW-1:0]    fwd_addr_reg [2];
    logic [hhph_pkg::COUNT_BITS-1:0] fwd_data_reg [2];

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            if (fwd_valid_reg[m] && (fwd_addr_reg[m] == p4_addr_reg[m])) begin
                hist_cur[m] = fwd_data_reg[m];
            end else begin
                hist_cur[m] = hist_rdata[m];
            end
            hist_inc[m] = (hist_cur[m] == hhph_pkg::COUNT_MAX) ? hist_cur[m] : hist_cur[m] + 1'b1;
            inc_we[m]   = p4_valid_reg && p4_event_reg && p4_hit_reg[m];
            if (sweep_reg) begin
                hist_we[m]    = 1'b1;
                hist_waddr[m] = sweep_addr_reg;
                hist_wdata[m] = '0;
            end else begin
                hist_we[m]    = inc_we[m];
                hist_waddr[m] = p4_addr_reg[m];
                hist_wdata[m] = hist_inc[m];
            end
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_hist
        hhph_ram #(
            .WIDTH (hhph_pkg::COUNT_BITS),
            .DEPTH (hhph_pkg::HIST_DEPTH)
        ) u_hist_ram (
            .aclk  (aclk),
            .we    (hist_we[g]),
            .waddr (hist_waddr[g]),
            .wdata (hist_wdata[g]),
            .raddr (p3_addr[g]),
            .rdata (hist_rdata[g])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fwd_valid_reg[g] <= 1'b0;
            end else begin
                fwd_valid_reg[g] <= inc_we[g] && !sweep_reg;
            end
        end

        always_ff @(posedge aclk) begin
            fwd_addr_reg[g] <= p4_addr_reg[g];
            fwd_data_reg[g] <= hist_inc[g];
        end
    end

    // clear sweep: runs after reset and once a clear reaches the write stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            clear_pend_reg <= 1'b0;
        end else begin
            if (s_acc && (s_req == hhph_pkg::REQ_CLEAR)) begin
                clear_pend_reg <= 1'b1;
            end else if (p4_valid_reg && p4_clear_reg) begin
                clear_pend_reg <= 1'b0;
            end
            if (sweep_reg) begin
                if (sweep_addr_reg == hhph_pkg::HIST_AW'(hhph_pkg::HIST_DEPTH - 1)) begin
                    sweep_reg      <= 1'b0;
                    sweep_addr_reg <= '0;
                end else begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
            end else if (p4_valid_reg && p4_clear_reg) begin
                sweep_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result beat and output queue
    // ------------------------------------------------------------------
    hhph_pkg::result_t res;
    hhph_pkg::result_t out_beat;

    assign res_push = p4_valid_reg && (p4_event_reg || p4_read_reg);

    always_comb begin
        res = '0;
        if (p4_read_reg) begin
            res.kind      = hhph_pkg::KIND_BIN;
            res.bin_count = p4_rb_ok_reg ? hist_cur[p4_metric_reg][hhph_pkg::BIN_W-1:0] : '0;
        end else begin
            res.kind     = hhph_pkg::KIND_EVENT;
            res.int_hit  = p4_hit_reg[0];
            res.int_x    = p4_x_reg[0];
            res.int_y    = p4_y_reg[0];
            res.peak_hit = p4_hit_reg[1];
            res.peak_x   = p4_x_reg[1];
            res.peak_y   = p4_y_reg[1];
        end
    end

    hhph_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .pop       (m_pop),
        .out_valid (m_valid),
        .out_data  (out_beat)
    );

    assign m_pop       = m_valid && m_ready;
    assign m_kind      = out_beat.kind;
    assign m_int_hit   = out_beat.int_hit;
    assign m_int_x     = out_beat.int_x;
    assign m_int_y     = out_beat.int_y;
    assign m_peak_hit  = out_beat.peak_hit;
    assign m_peak_x    = out_beat.peak_x;
    assign m_peak_y    = out_beat.peak_y;
    assign m_bin_count = out_beat.bin_count;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= hhph_pkg::FIFO_CW'(hhph_pkg::FIFO_DEPTH))
        else $error("result credit count beyond queue depth");

    a_push_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (cnt_reg != '0))
        else $error("result produced with no credit outstanding");

    a_no_inc_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_reg |-> !(inc_we[0] || inc_we[1]))
        else $error("bin increment overlaps histogram sweep");

    a_clear_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (p4_valid_reg && p4_clear_reg) |=> sweep_reg)
        else $error("clear reached write stage without starting sweep");

endmodule

[dv/hodoscope_hit_position_histogram_top_test.sv]
`timescale 1ns / 100ps
// self-checking testbench: directed and random requests against a cycle-free hit histogram model
module hodoscope_hit_position_histogram_top_test;

    localparam int RANDOM_ITEMS = 450;
    localparam int RX_HOLD_CYCLES = 150;
    // a clear or the reset sweep blocks the input while every histogram bin is zeroed, so allow plenty
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;
    localparam logic signed [hhph_pkg::VALUE_BITS-1:0] VAL_MAX =
        {1'b0, {(hhph_pkg::VALUE_BITS-1){1'b1}}};
    localparam logic signed [hhph_pkg::VALUE_BITS-1:0] VAL_MIN =
        {1'b1, {(hhph_pkg::VALUE_BITS-1){1'b0}}};

    typedef struct packed {
        hhph_pkg::req_t                          req;
        logic                                    axis;
        logic [hhph_pkg::FIBER_W-1:0]            fiber;
        logic [hhph_pkg::FIBER_W-1:0]            row;
        logic                                    metric;
        logic signed [hhph_pkg::VALUE_BITS-1:0]  int_value;
        logic signed [hhph_pkg::VALUE_BITS-1:0]  peak_value;
        logic signed [hhph_pkg::VALUE_BITS-1:0]  threshold_word;
        logic [hhph_pkg::GAIN_BITS-1:0]          gain_word;
        logic                                    last;
        logic                                    drain_first;  // hold the beat until all results are back
        logic                                    rx_hold;      // receiver holds off once this beat is taken
    } request_t;

    logic                                    aclk = 1'b0;
    logic                                    aresetn = 1'b0;
    logic                                    s_valid = 1'b0;
    logic                                    s_ready;
    logic [1:0]                              s_req_type = '0;
    logic                                    s_axis = 1'b0;
    logic [hhph_pkg::FIBER_W-1:0]            s_fiber = '0;
    logic [hhph_pkg::FIBER_W-1:0]            s_row = '0;
    logic                                    s_metric = 1'b0;
    logic signed [hhph_pkg::VALUE_BITS-1:0]  s_int_value = '0;
    logic signed [hhph_pkg::VALUE_BITS-1:0]  s_peak_value = '0;
    logic signed [hhph_pkg::VALUE_BITS-1:0]  s_threshold_word = '0;
    logic [hhph_pkg::GAIN_BITS-1:0]          s_gain_word = '0;
    logic                                    s_last_of_event = 1'b0;
    logic                                    rx_hold_mark = 1'b0;
    logic                                    m_valid;
    logic                                    m_ready = 1'b0;
    logic                                    m_kind;
    logic                                    m_int_hit;
    logic [hhph_pkg::FIBER_W-1:0]            m_int_x;
    logic [hhph_pkg::FIBER_W-1:0]            m_int_y;
    logic                                    m_peak_hit;
    logic [hhph_pkg::FIBER_W-1:0]            m_peak_x;
    logic [hhph_pkg::FIBER_W-1:0]            m_peak_y;
    logic [hhph_pkg::BIN_W-1:0]              m_bin_count;

    hodoscope_hit_position_histogram_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_axis           (s_axis),
        .s_fiber          (s_fiber),
        .s_row            (s_row),
        .s_metric         (s_metric),
        .s_int_value      (s_int_value),
        .s_peak_value     (s_peak_value),
        .s_threshold_word (s_threshold_word),
        .s_gain_word      (s_gain_word),
        .s_last_of_event  (s_last_of_event),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_int_hit        (m_int_hit),
        .m_int_x          (m_int_x),
        .m_int_y          (m_int_y),
        .m_peak_hit       (m_peak_hit),
        .m_peak_x         (m_peak_x),
        .m_peak_y         (m_peak_y),
        .m_bin_count      (m_bin_count)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // hit model: tables, running winners per (metric, axis) slot, histograms
    // slot = metric * 2 + axis
    // ---------------------------------------------------------------------
    logic signed [hhph_pkg::VALUE_BITS-1:0] thr_tab [4][hhph_pkg::FIBERS];
    logic [hhph_pkg::GAIN_BITS-1:0]         gain_tab [4][hhph_pkg::FIBERS];
    longint                                 lead_scaled [4];
    logic [hhph_pkg::FIBER_W-1:0]           lead_fiber [4];
    logic                                   lead_found [4];
    logic [hhph_pkg::COUNT_BITS-1:0]        bin_tally [2][hhph_pkg::FIBERS][hhph_pkg::FIBERS];

    hhph_pkg::result_t due_results [$];
    request_t          pending_requests [$];
    request_t          on_offer;

    int n_errors = 0;
    int n_beats_in = 0;
    int n_events = 0;
    int n_int_fills = 0;
    int n_peak_fills = 0;
    int n_reads = 0;
    int n_reads_nonzero = 0;
    int n_loads = 0;
    int n_clears = 0;

    function automatic void clear_leaders();
        for (int s = 0; s < 4; s++) begin
            lead_scaled[s] = 0;
            lead_fiber[s] = '0;
            lead_found[s] = 1'b0;
        end
    endfunction

    function automatic void wipe_histograms();
        for (int m = 0; m < 2; m++)
            for (int y = 0; y < hhph_pkg::FIBERS; y++)
                for (int x = 0; x < hhph_pkg::FIBERS; x++)
                    bin_tally[m][y][x] = '0;
    endfunction

    // fiber takes part only above its own threshold; gain-scaled value competes,
    // lower index wins a tie
    function automatic void weigh_fiber(int slot, int fib,
                                        logic signed [hhph_pkg::VALUE_BITS-1:0] raw);
        longint scaled;
        if (raw > thr_tab[slot][fib]) begin
            scaled = longint'(raw) * longint'(gain_tab[slot][fib]);
            if (!lead_found[slot] || scaled > lead_scaled[slot] ||
                (scaled == lead_scaled[slot] && fib < int'(lead_fiber[slot]))) begin
                lead_scaled[slot] = scaled;
                lead_fiber[slot] = hhph_pkg::FIBER_W'(fib);
                lead_found[slot] = 1'b1;
            end
        end
    endfunction

    function automatic void bump_bin(int m);
        int x;
        int y;
        x = lead_fiber[2 * m];
        y = lead_fiber[2 * m + 1];
        if (bin_tally[m][y][x] != hhph_pkg::COUNT_MAX)
            bin_tally[m][y][x] = bin_tally[m][y][x] + 1'b1;
    endfunction

    // advance the model by one accepted request beat, queueing any result it owes
    function automatic void process_request(request_t r);
        hhph_pkg::result_t res;
        int slot;
        res = '0;
        case (r.req)
            hhph_pkg::REQ_SAMPLE: begin
                if (r.fiber < hhph_pkg::FIBERS) begin
                    weigh_fiber(int'(r.axis), int'(r.fiber), r.int_value);
                    weigh_fiber(2 + int'(r.axis), int'(r.fiber), r.peak_value);
                end
                if (r.last) begin
                    res.kind = hhph_pkg::KIND_EVENT;
                    res.int_hit = lead_found[0] && lead_found[1];
                    res.peak_hit = lead_found[2] && lead_found[3];
                    res.int_x = lead_fiber[0];
                    res.int_y = lead_fiber[1];
                    res.peak_x = lead_fiber[2];
                    res.peak_y = lead_fiber[3];
                    if (res.int_hit) begin
                        bump_bin(0);
                        n_int_fills++;
                    end
                    if (res.peak_hit) begin
                        bump_bin(1);
                        n_peak_fills++;
                    end
                    due_results.push_back(res);
                    clear_leaders();
                    n_events++;
                end
            end
            hhph_pkg::REQ_LOAD: begin
                if (r.fiber < hhph_pkg::FIBERS) begin
                    slot = 2 * int'(r.metric) + int'(r.axis);
                    thr_tab[slot][r.fiber] = r.threshold_word;
                    gain_tab[slot][r.fiber] = r.gain_word;
                end
                n_loads++;
            end
            hhph_pkg::REQ_READ: begin
                res.kind = hhph_pkg::KIND_BIN;
                if (r.fiber < hhph_pkg::FIBERS && r.row < hhph_pkg::FIBERS)
                    res.bin_count = bin_tally[r.metric][r.row][r.fiber];
                if (res.bin_count != 0)
                    n_reads_nonzero++;
                due_results.push_back(res);
                n_reads++;
            end
            default: begin
                wipe_histograms();
                n_clears++;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // request builders: unused fields carry random junk the block must ignore
    // ---------------------------------------------------------------------
    function automatic request_t any_request();
        request_t r;
        r.req = hhph_pkg::req_t'($urandom_range(0, 3));
        r.axis = 1'($urandom);
        r.fiber = hhph_pkg::FIBER_W'($urandom);
        r.row = hhph_pkg::FIBER_W'($urandom);
        r.metric = 1'($urandom);
        r.int_value = hhph_pkg::VALUE_BITS'($urandom);
        r.peak_value = hhph_pkg::VALUE_BITS'($urandom);
        r.threshold_word = hhph_pkg::VALUE_BITS'($urandom);
        r.gain_word = hhph_pkg::GAIN_BITS'($urandom);
        r.last = 1'($urandom);
        r.drain_first = 1'b0;
        r.rx_hold = 1'b0;
        return r;
    endfunction

    function automatic request_t fiber_sample(logic axis, logic [hhph_pkg::FIBER_W-1:0] fib,
                                              logic signed [hhph_pkg::VALUE_BITS-1:0] iv,
                                              logic signed [hhph_pkg::VALUE_BITS-1:0] pv,
                                              logic last);
        request_t r;
        r = any_request();
        r.req = hhph_pkg::REQ_SAMPLE;
        r.axis = axis;
        r.fiber = fib;
        r.int_value = iv;
        r.peak_value = pv;
        r.last = last;
        return r;
    endfunction

    function automatic request_t table_load(logic metric, logic axis,
                                            logic [hhph_pkg::FIBER_W-1:0] fib,
                                            logic signed [hhph_pkg::VALUE_BITS-1:0] thr,
                                            logic [hhph_pkg::GAIN_BITS-1:0] gain);
        request_t r;
        r = any_request();
        r.req = hhph_pkg::REQ_LOAD;
        r.metric = metric;
        r.axis = axis;
        r.fiber = fib;
        r.threshold_word = thr;
        r.gain_word = gain;
        return r;
    endfunction

    function automatic request_t bin_read(logic metric, logic [hhph_pkg::FIBER_W-1:0] x,
                                          logic [hhph_pkg::FIBER_W-1:0] y);
        request_t r;
        r = any_request();
        r.req = hhph_pkg::REQ_READ;
        r.metric = metric;
        r.fiber = x;
        r.row = y;
        return r;
    endfunction

    function automatic request_t hist_clear();
        request_t r;
        r = any_request();
        r.req = hhph_pkg::REQ_CLEAR;
        return r;
    endfunction

    function automatic logic signed [hhph_pkg::VALUE_BITS-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return hhph_pkg::VALUE_BITS'(int'($urandom_range(0, 319)) - 64);
        else if (sel < 65)
            return hhph_pkg::VALUE_BITS'(int'($urandom_range(0, 44000)) - 4000);
        else if (sel < 85)
            return hhph_pkg::VALUE_BITS'($urandom);
        case ($urandom_range(0, 4))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return hhph_pkg::VALUE_BITS'(1);
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [hhph_pkg::VALUE_BITS-1:0] pick_threshold();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return hhph_pkg::VALUE_BITS'(int'($urandom_range(0, 200)) - 50);
        else if (sel < 85)
            return pick_value();
        else if (sel < 93)
            return VAL_MIN;
        return VAL_MAX;
    endfunction

    function automatic logic [hhph_pkg::GAIN_BITS-1:0] pick_gain();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return hhph_pkg::GAIN_BITS'($urandom_range(3000, 6000));
        else if (sel < 70)
            return hhph_pkg::GAIN_BITS'($urandom);
        else if (sel < 85)
            return '0;
        return '1;
    endfunction

    // most fibers come from a few hot ones at both ends so bins fill up and repeat
    function automatic logic [hhph_pkg::FIBER_W-1:0] pick_fiber();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return hhph_pkg::FIBER_W'($urandom_range(0, 3));
        else if (sel < 70)
            return hhph_pkg::FIBER_W'($urandom_range(hhph_pkg::FIBERS - 4,
                                                     hhph_pkg::FIBERS - 1));
        else if (sel < 95)
            return hhph_pkg::FIBER_W'($urandom_range(0, hhph_pkg::FIBERS - 1));
        return hhph_pkg::FIBER_W'($urandom_range(hhph_pkg::FIBERS, 31));
    endfunction

    int   n_queued = 0;
    logic drain_next = 1'b0;

    function automatic void enqueue(request_t r);
        r.drain_first = drain_next;
        drain_next = 1'b0;
        pending_requests.push_back(r);
        n_queued++;
    endfunction

    // ---------------------------------------------------------------------
    // driver: bursts of random length separated by random gaps
    // ---------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                process_request(on_offer);
                n_beats_in++;
            end
            // only move on once the current beat is gone
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() == 0 ||
                             (pending_requests[0].drain_first && due_results.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    on_offer = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= on_offer.req;
                    s_axis <= on_offer.axis;
                    s_fiber <= on_offer.fiber;
                    s_row <= on_offer.row;
                    s_metric <= on_offer.metric;
                    s_int_value <= on_offer.int_value;
                    s_peak_value <= on_offer.peak_value;
                    s_threshold_word <= on_offer.threshold_word;
                    s_gain_word <= on_offer.gain_word;
                    s_last_of_event <= on_offer.last;
                    rx_hold_mark <= on_offer.rx_hold;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // now and then a long burst with no gaps at all
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                               : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // receiver and result checker
    // ---------------------------------------------------------------------
    int hold_left = 0;
    int mode_left = 0;
    int ready_pct = 100;

    function automatic void match_field(string name, logic [hhph_pkg::BIN_W-1:0] want,
                                        logic [hhph_pkg::BIN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    function automatic void check_result();
        hhph_pkg::result_t want;
        if (due_results.size() == 0) begin
            $display("%0t: result beat with nothing outstanding: expected none, actual kind %0d",
                     $time, m_kind);
            n_errors++;
        end else begin
            want = due_results.pop_front();
            match_field("kind", hhph_pkg::BIN_W'(want.kind), hhph_pkg::BIN_W'(m_kind));
            match_field("int_hit", hhph_pkg::BIN_W'(want.int_hit),
                        hhph_pkg::BIN_W'(m_int_hit));
            match_field("int_x", hhph_pkg::BIN_W'(want.int_x), hhph_pkg::BIN_W'(m_int_x));
            match_field("int_y", hhph_pkg::BIN_W'(want.int_y), hhph_pkg::BIN_W'(m_int_y));
            match_field("peak_hit", hhph_pkg::BIN_W'(want.peak_hit),
                        hhph_pkg::BIN_W'(m_peak_hit));
            match_field("peak_x", hhph_pkg::BIN_W'(want.peak_x), hhph_pkg::BIN_W'(m_peak_x));
            match_field("peak_y", hhph_pkg::BIN_W'(want.peak_y), hhph_pkg::BIN_W'(m_peak_y));
            match_field("bin_count", want.bin_count, m_bin_count);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            // a marked request beat starts a long hold-off so the result queue backs up
            if (s_valid && s_ready && rx_hold_mark)
                hold_left = RX_HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                    mode_left = $urandom_range(20, 80);
                end else begin
                    mode_left--;
                end
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // watchdog: any stretch with no beat on either channel beyond the limit ends the run
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d requests and %0d results outstanding",
                     $time, IDLE_LIMIT, pending_requests.size(), due_results.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        request_t r;
        int sel;
        int n;
        int next_drain;
        int clears_left;
        logic hold_done;
        logic [hhph_pkg::FIBER_W-1:0] fx;
        logic [hhph_pkg::FIBER_W-1:0] fy;
        logic signed [hhph_pkg::VALUE_BITS-1:0] iv;
        logic signed [hhph_pkg::VALUE_BITS-1:0] pv;

        for (int s = 0; s < 4; s++)
            for (int f = 0; f < hhph_pkg::FIBERS; f++) begin
                thr_tab[s][f] = '0;
                gain_tab[s][f] = hhph_pkg::GAIN_UNITY;
            end
        wipe_histograms();
        clear_leaders();

        // directed: extreme tables, ties, zero gain, out-of-range fibers and bins
        enqueue(bin_read(1'b0, 5'd0, 5'd0));
        enqueue(table_load(1'b0, 1'b0, 5'd28, VAL_MIN, '1));
        enqueue(table_load(1'b1, 1'b1, 5'd0, VAL_MAX, '0));
        enqueue(table_load(1'b0, 1'b1, 5'd7, '0, '0));
        enqueue(table_load(1'b0, 1'b1, 5'd9, -24'sd1000, hhph_pkg::GAIN_UNITY));
        enqueue(table_load(1'b1, 1'b0, 5'd31, 24'sd5, 16'd5));
        // equal scaled values on fibers 5 and 2: fiber 2 must win
        enqueue(fiber_sample(1'b0, 5'd5, 24'sd500, 24'sd300, 1'b0));
        enqueue(fiber_sample(1'b0, 5'd2, 24'sd500, 24'sd300, 1'b0));
        // negative survivor loses to a zero-gain survivor
        enqueue(fiber_sample(1'b1, 5'd9, -24'sd10, VAL_MAX, 1'b0));
        enqueue(fiber_sample(1'b1, 5'd7, 24'sd100, VAL_MAX, 1'b0));
        enqueue(fiber_sample(1'b1, 5'd0, VAL_MIN, VAL_MAX, 1'b1));
        // only the X plane hits; the event is closed by an out-of-range fiber
        enqueue(fiber_sample(1'b0, 5'd28, VAL_MAX, VAL_MIN, 1'b0));
        enqueue(fiber_sample(1'b1, 5'd30, 24'sd50, 24'sd50, 1'b1));
        // empty event
        enqueue(fiber_sample(1'b1, 5'd29, VAL_MAX, VAL_MAX, 1'b1));
        r = table_load(1'b1, 1'b0, 5'd3, 24'sd20, 16'd8192);
        r.last = 1'b1;
        enqueue(r);
        enqueue(bin_read(1'b0, 5'd2, 5'd7));
        enqueue(bin_read(1'b1, 5'd2, 5'd7));
        enqueue(bin_read(1'b0, 5'd31, 5'd7));
        enqueue(bin_read(1'b1, 5'd2, 5'd31));
        r = hist_clear();
        r.last = 1'b1;
        enqueue(r);
        enqueue(bin_read(1'b0, 5'd2, 5'd7));
        enqueue(fiber_sample(1'b0, 5'd3, 24'sd21, 24'sd21, 1'b0));
        enqueue(fiber_sample(1'b1, 5'd4, 24'sd1, 24'sd1, 1'b1));
        enqueue(bin_read(1'b1, 5'd3, 5'd4));

        // random part: mostly well-formed events, with loads, reads and noise mixed in
        next_drain = n_queued + 60;
        clears_left = 2;
        hold_done = 1'b0;
        while (n_queued < 25 + RANDOM_ITEMS) begin
            if (n_queued >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 90;
            end
            sel = $urandom_range(0, 99);
            if (!hold_done && n_queued >= 220) begin
                // long receiver hold-off with a run of one-sample events behind it
                r = fiber_sample(1'($urandom), pick_fiber(), pick_value(), pick_value(), 1'b1);
                r.rx_hold = 1'b1;
                enqueue(r);
                repeat (24)
                    enqueue(fiber_sample(1'($urandom), pick_fiber(), pick_value(),
                                         pick_value(), 1'b1));
                hold_done = 1'b1;
            end else if (sel < 58) begin
                n = $urandom_range(1, 10);
                iv = pick_value();
                pv = pick_value();
                for (int i = 0; i < n; i++) begin
                    // keep the previous value now and then to provoke ties
                    if ($urandom_range(0, 3) != 0)
                        iv = pick_value();
                    if ($urandom_range(0, 3) != 0)
                        pv = pick_value();
                    enqueue(fiber_sample(1'($urandom), pick_fiber(), iv, pv, i == n - 1));
                end
            end else if (sel < 70) begin
                // back-to-back events on the same bin, then read it back
                fx = hhph_pkg::FIBER_W'($urandom_range(0, hhph_pkg::FIBERS - 1));
                fy = hhph_pkg::FIBER_W'($urandom_range(0, hhph_pkg::FIBERS - 1));
                n = $urandom_range(2, 5);
                repeat (n) begin
                    enqueue(fiber_sample(1'b0, fx,
                        hhph_pkg::VALUE_BITS'($urandom_range(300000, 8388607)),
                        hhph_pkg::VALUE_BITS'($urandom_range(300000, 8388607)), 1'b0));
                    enqueue(fiber_sample(1'b1, fy,
                        hhph_pkg::VALUE_BITS'($urandom_range(300000, 8388607)),
                        hhph_pkg::VALUE_BITS'($urandom_range(300000, 8388607)), 1'b1));
                end
                enqueue(bin_read(1'($urandom), fx, fy));
            end else if (sel < 82) begin
                repeat ($urandom_range(1, 3))
                    enqueue(table_load(1'($urandom), 1'($urandom), pick_fiber(),
                                       pick_threshold(), pick_gain()));
            end else if (sel < 95) begin
                enqueue(bin_read(1'($urandom), pick_fiber(), pick_fiber()));
            end else if (sel < 97 && clears_left > 0) begin
                enqueue(hist_clear());
                clears_left--;
            end else begin
                r = any_request();
                if (r.req == hhph_pkg::REQ_CLEAR)
                    r.req = hhph_pkg::REQ_READ;
                enqueue(r);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d request beats: %0d events (%0d integral, %0d peak bin fills),",
                 n_beats_in, n_events, n_int_fills, n_peak_fills);
        $display("%0d table loads, %0d bin reads (%0d non-zero), %0d histogram clears",
                 n_loads, n_reads, n_reads_nonzero, n_clears);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
src/hhph_pkg.sv
src/hhph_ram.sv
src/hhph_fifo.sv
src/hodoscope_hit_position_histogram_top.sv
dv/hodoscope_hit_position_histogram_top_test.sv
